/* src/rrts_pkg.sv */
// shared types and constants for the round-robin task scheduler
package rrts_pkg;

    localparam int DEF_MAX_TASKS = 64;

    localparam int CMD_W    = 2;
    localparam int SLOT_W   = 6;
    localparam int GEN_W    = 32;
    localparam int SLICE_W  = 8;
    localparam int IN_DW    = 8;
    localparam int OUT_DW   = 48;

    localparam logic [GEN_W-1:0]   GEN_MAX       = 32'hFFFF_FFFF;
    localparam logic [GEN_W-1:0]   GEN_FIRST     = 32'd1;
    localparam logic [GEN_W-1:0]   GEN_RESET     = 32'd2;
    localparam logic [SLICE_W-1:0] SLICE_RESET   = 8'd5;

    typedef enum logic [CMD_W-1:0] {
        CMD_CREATE   = 2'd0,
        CMD_FREE     = 2'd1,
        CMD_TICK     = 2'd2,
        CMD_SCHEDULE = 2'd3
    } sched_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_TAG
    } sched_state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic commit;
        logic load_out;
        logic load_tag;
    } sched_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_tag;
    } sched_stat_t;

endpackage

/* src/rrts_ctrl.sv */
// sequencing state machine for the task scheduler
module rrts_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  rrts_pkg::sched_stat_t stat,
    output rrts_pkg::sched_cmd_t  cmd
);
    import rrts_pkg::*;

    sched_state_t state_reg;
    sched_state_t state_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    logic         out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = stat.need_tag ? ST_TAG : ST_IDLE;
                end
            end
            ST_TAG:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_EXEC:
            begin
                cmd.commit   = out_free;
                cmd.load_out = out_free && !stat.need_tag;
            end
            ST_TAG:
            begin
                cmd.load_tag = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out || cmd.load_tag)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* src/rrts_dp.sv */
// slot pool, ready queue, time slice and result register of the scheduler
module rrts_dp #(
    parameter int MAX_TASKS = rrts_pkg::DEF_MAX_TASKS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rrts_pkg::sched_cmd_t          cmd,
    output rrts_pkg::sched_stat_t         stat,
    input  rrts_pkg::sched_op_t           in_command,
    input  logic [rrts_pkg::SLOT_W-1:0]   in_slot,
    input  logic                          cfg_we,
    input  logic [rrts_pkg::SLICE_W-1:0]  cfg_wdata,
    output logic                          out_ok,
    output logic [rrts_pkg::SLOT_W-1:0]   out_task_slot,
    output logic [rrts_pkg::GEN_W-1:0]    out_task_generation,
    output logic                          out_expired,
    output logic                          out_queue_overflow
);
    import rrts_pkg::*;

    localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam logic [SW-1:0] LAST_IDX = SW'(MAX_TASKS - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(MAX_TASKS);

    // memories
    logic [GEN_W-1:0] tag_mem  [MAX_TASKS];
    logic [SW-1:0]    fifo_mem [MAX_TASKS];

    // control state
    logic [MAX_TASKS-1:0] used_reg, used_next;
    logic                 init0_reg, init0_next;
    logic [SW-1:0]        head_reg, head_next;
    logic [SW-1:0]        tail_reg, tail_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        used_count_reg, used_count_next;
    logic [SW-1:0]        running_reg, running_next;
    logic [GEN_W-1:0]     running_tag_reg, running_tag_next;
    logic [GEN_W-1:0]     next_gen_reg, next_gen_next;
    logic [SLICE_W-1:0]   time_left_reg, time_left_next;
    logic [SLICE_W-1:0]   time_slice_reg;

    // captured item and lookups
    sched_op_t            cmd_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic [SW-1:0]        free_idx_reg;
    logic                 free_found_reg;
    logic [SW-1:0]        pop_reg;
    logic [GEN_W-1:0]     tag_rd_reg;
    logic                 pop_used_reg;
    logic                 pop_init_reg;

    // combinational
    logic [SW-1:0]        free_idx;
    logic                 free_found;
    logic [SW-1:0]        slot_idx;
    logic                 slot_in_range;
    logic                 free_hit;
    logic                 fifo_we;
    logic [SW-1:0]        fifo_wdata;
    logic                 tag_we;
    logic                 tag_rd_en;
    logic [GEN_W-1:0]     pop_tag;
    logic                 res_ok;
    logic [SW-1:0]        res_slot;
    logic [GEN_W-1:0]     res_tag;
    logic                 res_ovf;

    function automatic logic [SW-1:0] ptr_inc(input logic [SW-1:0] p);
        logic [SW-1:0] r;
        r = (p == LAST_IDX) ? '0 : p + 1'b1;
        return r;
    endfunction

    // lowest free slot
    always_comb
    begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int i = MAX_TASKS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_idx   = SW'(i);
                free_found = 1'b1;
            end
        end
    end

    assign slot_in_range = (32'(slot_reg) < 32'(MAX_TASKS));
    assign slot_idx      = SW'(slot_reg);
    assign free_hit      = slot_in_range && used_reg[slot_idx];
    assign pop_tag       = !pop_used_reg ? '0 : (pop_init_reg ? GEN_FIRST : tag_rd_reg);

    assign stat.need_tag = (cmd_reg == CMD_SCHEDULE) && (count_reg != '0);

    always_comb
    begin
        used_next        = used_reg;
        init0_next       = init0_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        count_next       = count_reg;
        used_count_next  = used_count_reg;
        running_next     = running_reg;
        running_tag_next = running_tag_reg;
        next_gen_next    = next_gen_reg;
        time_left_next   = time_left_reg;
        fifo_we          = 1'b0;
        fifo_wdata       = running_reg;
        tag_we           = 1'b0;
        tag_rd_en        = 1'b0;
        res_ok           = 1'b0;
        res_slot         = running_reg;
        res_tag          = running_tag_reg;
        res_ovf          = 1'b0;

        if (cmd.commit)
        begin
            case (cmd_reg)
                CMD_CREATE:
                begin
                    if (used_count_reg < FULL_CNT)
                    begin
                        if (count_reg >= FULL_CNT)
                        begin
                            res_ovf = 1'b1;
                        end
                        else if (free_found_reg)
                        begin
                            used_next[free_idx_reg] = 1'b1;
                            tag_we                  = 1'b1;
                            if (free_idx_reg == '0)
                            begin
                                init0_next = 1'b0;
                            end
                            if (free_idx_reg == running_reg)
                            begin
                                running_tag_next = next_gen_reg;
                            end
                            used_count_next = used_count_reg + 1'b1;
                            next_gen_next   = (next_gen_reg == GEN_MAX) ? GEN_FIRST
                                                                        : next_gen_reg + 1'b1;
                            fifo_we    = 1'b1;
                            fifo_wdata = free_idx_reg;
                            tail_next  = ptr_inc(tail_reg);
                            count_next = count_reg + 1'b1;
                            res_ok     = 1'b1;
                            res_slot   = free_idx_reg;
                            res_tag    = next_gen_reg;
                        end
                    end
                end
                CMD_FREE:
                begin
                    if (free_hit)
                    begin
                        used_next[slot_idx] = 1'b0;
                        used_count_next     = used_count_reg - 1'b1;
                        res_ok              = 1'b1;
                        if (slot_idx == running_reg)
                        begin
                            running_tag_next = '0;
                            res_tag          = '0;
                        end
                    end
                end
                CMD_TICK:
                begin
                    if (time_left_reg != '0)
                    begin
                        time_left_next = time_left_reg - 1'b1;
                    end
                end
                CMD_SCHEDULE:
                begin
                    // pop and push in one step, so the count stays put
                    if (count_reg != '0)
                    begin
                        head_next      = ptr_inc(head_reg);
                        tail_next      = ptr_inc(tail_reg);
                        fifo_we        = 1'b1;
                        fifo_wdata     = running_reg;
                        running_next   = pop_reg;
                        time_left_next = time_slice_reg;
                        tag_rd_en      = 1'b1;
                    end
                end
                default:
                begin
                    res_ok = 1'b0;
                end
            endcase
        end

        if (cmd.load_tag)
        begin
            running_tag_next = pop_tag;
        end
    end

    // memory ports
    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[free_idx_reg] <= next_gen_reg;
        end
        if (tag_rd_en)
        begin
            tag_rd_reg <= tag_mem[pop_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fifo_we)
        begin
            fifo_mem[tail_reg] <= fifo_wdata;
        end
        if (cmd.capture)
        begin
            pop_reg <= fifo_mem[head_reg];
        end
    end

    // captured item, search result and output word
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg        <= in_command;
            slot_reg       <= in_slot;
            free_idx_reg   <= free_idx;
            free_found_reg <= free_found;
        end
        if (tag_rd_en)
        begin
            pop_used_reg <= used_reg[pop_reg];
            pop_init_reg <= init0_reg && (pop_reg == '0);
        end
        if (cmd.load_out)
        begin
            out_ok              <= res_ok;
            out_task_slot       <= SLOT_W'(res_slot);
            out_task_generation <= res_tag;
            out_expired         <= (time_left_next == '0);
            out_queue_overflow  <= res_ovf;
        end
        else if (cmd.load_tag)
        begin
            out_ok              <= 1'b1;
            out_task_slot       <= SLOT_W'(running_reg);
            out_task_generation <= pop_tag;
            out_expired         <= (time_left_reg == '0);
            out_queue_overflow  <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg        <= MAX_TASKS'(1);
            init0_reg       <= 1'b1;
            head_reg        <= '0;
            tail_reg        <= '0;
            count_reg       <= '0;
            used_count_reg  <= CW'(1);
            running_reg     <= '0;
            running_tag_reg <= GEN_FIRST;
            next_gen_reg    <= GEN_RESET;
            time_left_reg   <= '0;
            time_slice_reg  <= SLICE_RESET;
        end
        else
        begin
            used_reg        <= used_next;
            init0_reg       <= init0_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            count_reg       <= count_next;
            used_count_reg  <= used_count_next;
            running_reg     <= running_next;
            running_tag_reg <= running_tag_next;
            next_gen_reg    <= next_gen_next;
            time_left_reg   <= time_left_next;
            if (cfg_we)
            begin
                time_slice_reg <= cfg_wdata;
            end
        end
    end

endmodule

/* src/round_robin_task_scheduler_top.sv */
// top level of the round-robin task scheduler with time slice
//
// usage
// - command words enter on the s_ side: s_tuser carries the command (create,
//   free, tick, schedule), s_tdata[5:0] the slot to free
// - one result word per command leaves on the m_ side: ok, task slot, its
//   generation tag, the expired flag and the queue overflow flag
// - cfg_we/cfg_wdata load the time slice; write only while the block is idle
// timing
// - create, free and tick pass from accept through the commit state to the
//   result; a schedule that switches tasks adds a tag state, the registered read
//   of the tag memory at the slot popped from the ready queue
// - one command is in flight at a time; the next is taken once the
//   result has been moved into the output register
// reset
// - slot 0 runs with generation 1 and is taken in the pool, the ready queue is
//   empty, next generation is 2, time left is 0 and the time slice is 5
// stall
// - the result sits in the output register until m_tready; while it waits
//   the next command is accepted and held until the output register frees
module round_robin_task_scheduler_top #(
    parameter int MAX_TASKS = rrts_pkg::DEF_MAX_TASKS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // command word in
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rrts_pkg::IN_DW-1:0]    s_tdata,   // [5:0] slot, [7:6] zero
    input  logic [rrts_pkg::CMD_W-1:0]    s_tuser,   // [1:0] command
    // result word out
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rrts_pkg::OUT_DW-1:0]   m_tdata,   // [0] ok, [6:1] task_slot,
                                                     // [38:7] task_generation,
                                                     // [39] expired,
                                                     // [40] queue_overflow, [47:41] zero
    // time slice register
    input  logic                          cfg_we,
    input  logic [rrts_pkg::SLICE_W-1:0]  cfg_wdata
);
    import rrts_pkg::*;

    sched_cmd_t          cmd;
    sched_stat_t         stat;
    logic                out_ok;
    logic [SLOT_W-1:0]   out_task_slot;
    logic [GEN_W-1:0]    out_task_generation;
    logic                out_expired;
    logic                out_queue_overflow;

    // state machine: accept, commit, result load
    rrts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // slot pool, ready queue and result register
    rrts_dp #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .stat                (stat),
        .in_command          (sched_op_t'(s_tuser)),
        .in_slot             (s_tdata[SLOT_W-1:0]),
        .cfg_we              (cfg_we),
        .cfg_wdata           (cfg_wdata),
        .out_ok              (out_ok),
        .out_task_slot       (out_task_slot),
        .out_task_generation (out_task_generation),
        .out_expired         (out_expired),
        .out_queue_overflow  (out_queue_overflow)
    );

    // pack result fields, lowest field first, zero pad to whole bytes
    assign m_tdata = {
        (OUT_DW - (SLOT_W + GEN_W + 3))'(0),
        out_queue_overflow,
        out_expired,
        out_task_generation,
        out_task_slot,
        out_ok
    };

endmodule
